// ----- rtl/core/rpmr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rpmr_pkg;

    localparam int CORDIC_ITERS = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_QBITS    = 33;

    // stage numbers, counted from the input register
    localparam int ST_ROOT  = 34;
    localparam int ST_RATE  = 69;
    localparam int ST_OUT   = 70;

    localparam logic [31:0] ANG_ZERO = 32'h0000_0000;
    localparam logic [31:0] ANG_PI   = 32'h8000_0000;
    localparam logic [31:0] ANG_PI_2 = 32'h4000_0000;
    localparam logic [31:0] ANG_M_PI_2 = 32'hC000_0000;

    // round(atan(2^-i) * 2^32 / (2*pi))
    localparam logic [31:0] ATAN_TAB [CORDIC_ITERS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic zero;
        logic ovf;
        logic neg;
    } div_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/rpmr_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpmr_sqrt
    import rpmr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] radicand,
    output logic      [31:0] root
);

    logic [63:0] n_reg    [1:SQRT_STEPS];
    logic [34:0] rem_reg  [1:SQRT_STEPS];
    logic [31:0] root_reg [1:SQRT_STEPS];

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        logic [63:0] n_in;
        logic [34:0] rem_in;
        logic [31:0] root_in;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic        ge;

        if (k == 0) begin : g_first
            assign n_in    = radicand;
            assign rem_in  = '0;
            assign root_in = '0;
        end else begin : g_next
            assign n_in    = n_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
        end

        assign rem_sh = {rem_in[32:0], n_in[63:62]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1]    <= {n_in[61:0], 2'b00};
                rem_reg[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k+1] <= {root_in[30:0], ge};
            end
        end
    end

    assign root = root_reg[SQRT_STEPS];

endmodule

`default_nettype wire

// ----- rtl/core/rpmr_cordic.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpmr_cordic
    import rpmr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] x_in,
    input  wire logic signed [31:0] y_in,
    output logic             [31:0] angle
);

    logic signed [63:0] x_reg  [0:CORDIC_ITERS];
    logic signed [63:0] y_reg  [0:CORDIC_ITERS];
    logic        [31:0] z_reg  [0:CORDIC_ITERS];
    logic               sp_reg [0:CORDIC_ITERS];
    logic        [31:0] sv_reg [0:CORDIC_ITERS];

    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic               sp_next;
    logic        [31:0] sv_next;

    // prescale by 2^28, fold left half plane onto the right
    assign xs = {{4{x_in[31]}}, x_in, 28'd0};
    assign ys = {{4{y_in[31]}}, y_in, 28'd0};

    always_comb
    begin
        sp_next = 1'b0;
        sv_next = ANG_ZERO;
        if (y_in == '0)
        begin
            sp_next = 1'b1;
            sv_next = x_in[31] ? ANG_PI : ANG_ZERO;
        end
        else if (x_in == '0)
        begin
            sp_next = 1'b1;
            sv_next = y_in[31] ? ANG_M_PI_2 : ANG_PI_2;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]  <= x_in[31] ? -xs : xs;
            y_reg[0]  <= x_in[31] ? -ys : ys;
            z_reg[0]  <= x_in[31] ? ANG_PI : ANG_ZERO;
            sp_reg[0] <= sp_next;
            sv_reg[0] <= sv_next;
        end
    end

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_iter
        logic signed [63:0] dx;
        logic signed [63:0] dy;
        logic               pos;

        assign dx  = y_reg[k] >>> k;
        assign dy  = x_reg[k] >>> k;
        assign pos = !y_reg[k][63];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[k+1]  <= pos ? (x_reg[k] + dx) : (x_reg[k] - dx);
                y_reg[k+1]  <= pos ? (y_reg[k] - dy) : (y_reg[k] + dy);
                z_reg[k+1]  <= pos ? (z_reg[k] + ATAN_TAB[k]) : (z_reg[k] - ATAN_TAB[k]);
                sp_reg[k+1] <= sp_reg[k];
                sv_reg[k+1] <= sv_reg[k];
            end
        end
    end

    assign angle = sp_reg[CORDIC_ITERS] ? sv_reg[CORDIC_ITERS] : z_reg[CORDIC_ITERS];

endmodule

`default_nettype wire

// ----- rtl/core/rpmr_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rpmr_div
    import rpmr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic        [63:0] mag,
    input  wire logic               neg,
    input  wire logic        [31:0] divisor,
    output logic signed      [31:0] rate
);

    logic [64:0]             rem_reg [0:DIV_QBITS];
    logic [DIV_QBITS-1:0]    q_reg   [0:DIV_QBITS];
    logic [31:0]             d_reg   [0:DIV_QBITS];
    div_ctl_t                ctl_reg [0:DIV_QBITS];
    logic signed [31:0]      rate_reg;

    logic [64:0] num;
    div_ctl_t    ctl_next;

    // round half away from zero on the magnitude
    assign num = {1'b0, mag} + {34'd0, divisor[31:1]};

    always_comb
    begin
        ctl_next.zero = (divisor == '0);
        ctl_next.ovf  = (num >= {divisor, 33'd0});
        ctl_next.neg  = neg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            q_reg[0]   <= '0;
            d_reg[0]   <= divisor;
            ctl_reg[0] <= ctl_next;
        end
    end

    for (genvar k = 0; k < DIV_QBITS; k++) begin : g_bit
        localparam int SH = DIV_QBITS - 1 - k;
        logic [65:0] dvs;
        logic [65:0] rem_w;
        logic        ge;

        assign dvs   = {34'd0, d_reg[k]} << SH;
        assign rem_w = {1'b0, rem_reg[k]};
        assign ge    = (rem_w >= dvs);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= ge ? 65'(rem_w - dvs) : rem_reg[k];
                q_reg[k+1]   <= {q_reg[k][DIV_QBITS-2:0], ge};
                d_reg[k+1]   <= d_reg[k];
                ctl_reg[k+1] <= ctl_reg[k];
            end
        end
    end

    logic [DIV_QBITS-1:0] q_fin;
    div_ctl_t             c_fin;
    logic signed [31:0]   rate_next;

    assign q_fin = q_reg[DIV_QBITS];
    assign c_fin = ctl_reg[DIV_QBITS];

    always_comb
    begin
        if (c_fin.zero)
            rate_next = '0;
        else if (c_fin.neg)
        begin
            if (c_fin.ovf || q_fin > 33'h0_8000_0000)
                rate_next = 32'sh8000_0000;
            else
                rate_next = 32'(-q_fin);
        end
        else
        begin
            if (c_fin.ovf || q_fin > 33'h0_7FFF_FFFF)
                rate_next = 32'sh7FFF_FFFF;
            else
                rate_next = 32'(q_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rate_reg <= rate_next;
    end

    assign rate = rate_reg;

endmodule

`default_nettype wire

// ----- rtl/core/radar_polar_measurement_residual_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Radar measurement model and residual for a Cartesian track state.
// Input channel (in_valid / in_stall): one word holds the state position and
// velocity (Q16.16) and one radar measurement (range, bearing, range rate).
// Output channel (out_valid / out_stall): one word holds the predicted range,
// bearing (binary angle, 2^31 = pi) and range rate, plus the residuals.
// Throughput: one word per cycle while out_stall does not hold the pipeline.
// The pipeline depth is set by the 32-step root pipeline followed by the 33-bit
// rate divider pipeline; the 32-iteration CORDIC runs beside the root.
// Every stage moves on a single advance enable. When out_valid is high and
// out_stall is asserted the whole pipeline holds, and in_stall follows in
// the same cycle; nothing is dropped or duplicated.
// Reset clears all valid bits; the pipeline is empty and ready after reset.
module radar_polar_measurement_residual_core
    import rpmr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic        [31:0] meas_range,
    input  wire logic signed [31:0] meas_bearing,
    input  wire logic signed [31:0] meas_range_rate,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [31:0] pred_range,
    output logic signed      [31:0] pred_bearing,
    output logic signed      [31:0] pred_range_rate,
    output logic signed      [32:0] res_range,
    output logic signed      [31:0] res_bearing,
    output logic signed      [32:0] res_range_rate
);

    logic en;
    logic vld_reg [1:ST_OUT];

    assign en       = !(vld_reg[ST_OUT] && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= ST_OUT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= in_valid;
            for (int k = 2; k <= ST_OUT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 1: products
    logic signed [63:0] pxx_reg;
    logic signed [63:0] pyy_reg;
    logic signed [63:0] pxv_reg;
    logic signed [63:0] pyv_reg;
    logic signed [31:0] px_reg;
    logic signed [31:0] py_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pxx_reg <= pos_x * pos_x;
            pyy_reg <= pos_y * pos_y;
            pxv_reg <= pos_x * vel_x;
            pyv_reg <= pos_y * vel_y;
            px_reg  <= pos_x;
            py_reg  <= pos_y;
        end
    end

    // stage 2: squared range and dot product magnitude
    logic        [63:0] sq_reg;
    logic signed [64:0] dot;
    logic        [64:0] dot_abs;

    assign dot     = 65'(pxv_reg) + 65'(pyv_reg);
    assign dot_abs = dot[64] ? -dot : dot;

    logic [63:0] mag_dl [2:ST_ROOT];
    logic        neg_dl [2:ST_ROOT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg    <= 64'(pxx_reg) + 64'(pyy_reg);
            mag_dl[2] <= dot_abs[63:0];
            neg_dl[2] <= dot[64];
            for (int k = 3; k <= ST_ROOT; k++)
            begin
                mag_dl[k] <= mag_dl[k-1];
                neg_dl[k] <= neg_dl[k-1];
            end
        end
    end

    logic [31:0] root;
    logic [31:0] angle;
    logic signed [31:0] rate;

    rpmr_sqrt u_sqrt (
        .clk      (clk),
        .en       (en),
        .radicand (sq_reg),
        .root     (root)
    );

    rpmr_cordic u_cordic (
        .clk   (clk),
        .en    (en),
        .x_in  (px_reg),
        .y_in  (py_reg),
        .angle (angle)
    );

    rpmr_div u_div (
        .clk     (clk),
        .en      (en),
        .mag     (mag_dl[ST_ROOT]),
        .neg     (neg_dl[ST_ROOT]),
        .divisor (root),
        .rate    (rate)
    );

    // side lines up to the rate stage
    logic [31:0] mr_dl  [1:ST_RATE];
    logic [31:0] mb_dl  [1:ST_RATE];
    logic [31:0] mrr_dl [1:ST_RATE];
    logic [31:0] r_dl   [ST_ROOT+1:ST_RATE];
    logic [31:0] z_dl   [ST_ROOT+1:ST_RATE];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mr_dl[1]  <= meas_range;
            mb_dl[1]  <= meas_bearing;
            mrr_dl[1] <= meas_range_rate;
            for (int k = 2; k <= ST_RATE; k++)
            begin
                mr_dl[k]  <= mr_dl[k-1];
                mb_dl[k]  <= mb_dl[k-1];
                mrr_dl[k] <= mrr_dl[k-1];
            end
            r_dl[ST_ROOT+1] <= root;
            z_dl[ST_ROOT+1] <= angle;
            for (int k = ST_ROOT + 2; k <= ST_RATE; k++)
            begin
                r_dl[k] <= r_dl[k-1];
                z_dl[k] <= z_dl[k-1];
            end
        end
    end

    // output stage
    logic [31:0]        pr_reg;
    logic [31:0]        pb_reg;
    logic signed [31:0] prr_reg;
    logic signed [32:0] rr_reg;
    logic [31:0]        rb_reg;
    logic signed [32:0] rrr_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg  <= r_dl[ST_RATE];
            pb_reg  <= z_dl[ST_RATE];
            prr_reg <= rate;
            rr_reg  <= {1'b0, mr_dl[ST_RATE]} - {1'b0, r_dl[ST_RATE]};
            rb_reg  <= mb_dl[ST_RATE] - z_dl[ST_RATE];
            rrr_reg <= {mrr_dl[ST_RATE][31], mrr_dl[ST_RATE]} - {rate[31], rate};
        end
    end

    assign out_valid       = vld_reg[ST_OUT];
    assign pred_range      = pr_reg;
    assign pred_bearing    = pb_reg;
    assign pred_range_rate = prr_reg;
    assign res_range       = rr_reg;
    assign res_bearing     = rb_reg;
    assign res_range_rate  = rrr_reg;

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stall without output back-pressure");

    a_origin_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pred_range == '0) |-> (pred_range_rate == '0))
        else $error("nonzero range rate at zero range");

    a_origin_bearing: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pred_range == '0) |-> (pred_bearing == '0))
        else $error("nonzero bearing at origin");

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import rpmr_pkg::*;

    typedef struct {
        logic [31:0] rng;
        logic [31:0] brg;
        logic [31:0] rate;
        logic [32:0] rres;
        logic [31:0] bres;
        logic [32:0] rrres;
    } polar_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [31:0] meas_range;
    logic signed [31:0] meas_bearing, meas_range_rate;
    logic out_valid;
    logic out_stall;
    logic [31:0] pred_range;
    logic signed [31:0] pred_bearing, pred_range_rate;
    logic signed [32:0] res_range;
    logic signed [31:0] res_bearing;
    logic signed [32:0] res_range_rate;

    polar_t expected_q[$];
    int errors;
    int words_sent;
    int words_checked;
    int burst_left;
    int stall_mode;

    radar_polar_measurement_residual_core dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [63:0] isqrt(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'h1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] bearing_calc(input longint x, input longint y);
        logic [31:0] z;
        longint dx, dy;
        z = ANG_ZERO;
        if (y == 0)
            return (x < 0) ? ANG_PI : ANG_ZERO;
        if (x == 0)
            return (y > 0) ? ANG_PI_2 : ANG_M_PI_2;
        x = x * 268435456;
        y = y * 268435456;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = ANG_PI;
        end
        for (int i = 0; i < CORDIC_ITERS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TAB[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint rate_calc(input longint px, input longint py,
                                         input longint vx, input longint vy,
                                         input logic [63:0] r);
        logic signed [65:0] d;
        logic [65:0] mag;
        logic [65:0] q;
        logic neg;
        if (r == 0)
            return 0;
        d = 66'(px * vx) + 66'(py * vy);
        neg = d < 0;
        mag = neg ? -d : d;
        q = (mag + (r >> 1)) / r;
        if (neg)
            return (q > 66'd2147483648) ? -64'sd2147483648 : -longint'(q);
        return (q > 66'd2147483647) ? 64'sd2147483647 : longint'(q);
    endfunction

    function automatic polar_t predict_polar(input logic signed [31:0] px,
                                             input logic signed [31:0] py,
                                             input logic signed [31:0] vx,
                                             input logic signed [31:0] vy,
                                             input logic [31:0] mr,
                                             input logic [31:0] mb,
                                             input logic signed [31:0] mrr);
        polar_t p;
        logic [63:0] sq;
        logic [63:0] r;
        longint rr;
        sq = 64'(longint'(px) * px) + 64'(longint'(py) * py);
        r = isqrt(sq);
        rr = rate_calc(px, py, vx, vy, r);
        p.rng = r[31:0];
        p.brg = bearing_calc(px, py);
        p.rate = rr[31:0];
        p.rres = 33'({1'b0, mr} - r[32:0]);
        p.bres = mb - p.brg;
        p.rrres = 33'(longint'(mrr) - rr);
        return p;
    endfunction

    task automatic send_word(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] mr, input logic [31:0] mb,
                             input logic [31:0] mrr);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        in_valid <= 1'b1;
        pos_x <= px;
        pos_y <= py;
        vel_x <= vx;
        vel_y <= vy;
        meas_range <= mr;
        meas_bearing <= mb;
        meas_range_rate <= mrr;
        expected_q.push_back(predict_polar(px, py, vx, vy, mr, mb, mrr));
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: range %h", pred_range);
            end
            else
            begin
                polar_t e;
                e = expected_q.pop_front();
                words_checked++;
                if (pred_range !== e.rng || pred_bearing !== e.brg
                    || pred_range_rate !== e.rate || res_range !== e.rres
                    || res_bearing !== e.bres || res_range_rate !== e.rrres)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %h %h %h %h %h %h got %h %h %h %h %h %h",
                                 e.rng, e.brg, e.rate, e.rres, e.bres, e.rrres,
                                 pred_range, pred_bearing, pred_range_rate,
                                 res_range, res_bearing, res_range_rate);
                end
            end
        end
    end

    // receiver stall pattern: phases of none, light and heavy stalling
    always @(posedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    task automatic test_axes();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_word(0, 0, 0, 0, 0, 0, 0);
        send_word(0, 0, mx, mn, 32'hFFFF_FFFF, mx, mn);
        send_word(32'h0001_0000, 0, 32'h0001_0000, 0, 32'h0001_0000, 0, 0);
        send_word(0, 32'h0001_0000, 0, 0, 0, ANG_PI_2, 0);
        send_word(0, 32'hFFFF_0000, 0, mx, 0, ANG_M_PI_2, mx);
        send_word(32'hFFFF_0000, 0, mx, 0, 0, ANG_PI, 0);
        send_word(mn, 0, mn, 0, 32'hFFFF_FFFF, mn, mn);
        send_word(mx, 0, mx, 0, 0, mx, mx);
        send_word(0, mn, 0, mn, 0, mn, mx);
    endtask

    task automatic test_extremes();
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        send_word(mn, mn, mn, mn, 32'hFFFF_FFFF, mx, mn);
        send_word(mx, mx, mx, mx, 0, mn, mx);
        send_word(mn, mx, mx, mn, 32'h8000_0000, 0, 0);
        send_word(1, 1, mx, mx, 1, 1, 1);
        send_word(1, 0, mx, 0, 0, 0, mn);
        send_word(32'hFFFF_FFFF, 1, mn, mx, 0, 0, 0);
        send_word(1, 32'hFFFF_FFFF, mx, mn, 0, mn, 0);
        send_word(32'h0000_0100, 32'h0000_0100, mx, mx, 0, 0, 0);
        send_word(3, 4, 32'h0000_0001, 32'h0000_0001, 5, 0, 0);
    endtask

    task automatic test_flush();
        idle_input();
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_random(input int n);
        logic [31:0] px, py;
        for (int i = 0; i < n; i++)
        begin
            px = $urandom;
            py = $urandom;
            case ($urandom_range(0, 5))
                0: begin px = $signed(px) >>> $urandom_range(8, 31); end
                1: begin py = $signed(py) >>> $urandom_range(8, 31); end
                2: begin px = 0; end
                3: begin py = 0; end
                default: ;
            endcase
            send_word(px, py, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        stall_mode = 0;
        pos_x = 0;
        pos_y = 0;
        vel_x = 0;
        vel_y = 0;
        meas_range = 0;
        meas_bearing = 0;
        meas_range_rate = 0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_axes();
        test_extremes();
        test_flush();
        test_random(600);
        test_flush();
        test_random(650);
        test_flush();
        repeat (100) @(posedge clk);
        $display("covered %0d words, %0d results checked", words_sent, words_checked);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
